// ===== rtl/core/rtfl_pkg.sv =====
// shared types and constants for the record table free list
`default_nettype none

package rtfl_pkg;

  localparam int unsigned REQ_W    = 2;
  localparam int unsigned SLOT_W   = 8;
  localparam int unsigned WORD_W   = 64;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD    = 2'd0,
    REQ_READ   = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_NOP    = 2'd3
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_DELETED   = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_UNWRITTEN = 2'd3
  } status_e;

endpackage

`default_nettype wire

// ===== rtl/core/rtfl_if.sv =====
// request and response channel interfaces
`default_nettype none

interface rtfl_req_if;
  logic                            valid;
  logic                            ready;
  logic [rtfl_pkg::REQ_W-1:0]      req_type;
  logic [rtfl_pkg::SLOT_W-1:0]     slot;
  logic [rtfl_pkg::WORD_W-1:0]     record_data;

  modport source (output valid, output req_type, output slot, output record_data,
                  input ready);
  modport sink   (input valid, input req_type, input slot, input record_data,
                  output ready);
endinterface

interface rtfl_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [rtfl_pkg::SLOT_W-1:0]     slot_used;
  logic [rtfl_pkg::WORD_W-1:0]     data_out;
  logic [rtfl_pkg::STATUS_W-1:0]   status;

  modport source (output valid, output slot_used, output data_out, output status,
                  input ready);
  modport sink   (input valid, input slot_used, input data_out, input status,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/record_table_free_list_unit.sv =====
// A beat is latched, then executed: one slot of the synchronous payload and link
// memories is read and, for add and remove, written; the result is registered
// once the output register is free or being taken, and no new request is taken
// until then. Reset empties the free list and clears the fill count; memory
// contents are not cleared, slots at or above the fill count return no data.
`default_nettype none

module record_table_free_list_unit #(
  parameter int unsigned SLOTS     = 256,
  parameter int unsigned DATA_BITS = 64
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  rtfl_req_if.sink      req_i,
  rtfl_rsp_if.source    rsp_o
);

  localparam int unsigned AW    = $clog2(SLOTS);
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);
  localparam int unsigned SW    = rtfl_pkg::SLOT_W;
  localparam int unsigned WW    = rtfl_pkg::WORD_W;
  localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOTS);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  state_e                      state_q, state_d;
  rtfl_pkg::req_e              req_q;
  logic [SW-1:0]               slot_q;
  logic [DATA_BITS-1:0]        data_q;
  logic [CNT_W-1:0]            free_head_q, free_head_d;
  logic [CNT_W-1:0]            used_count_q, used_count_d;

  logic                        out_valid_q, out_valid_d;
  logic [SW-1:0]               out_slot_q, out_slot_d;
  logic [WW-1:0]               out_data_q, out_data_d;
  rtfl_pkg::status_e           out_status_q, out_status_d;

  logic                        accept;
  logic                        fire;
  logic [AW-1:0]               raddr;
  logic [AW+SW-1:0]            in_slot_ext;
  logic [AW+SW-1:0]            q_slot_ext;
  logic [AW-1:0]               slot_addr_q;
  logic [CNT_W+SW-1:0]         cmp_slot;
  logic [CNT_W+SW-1:0]         cmp_count;
  logic                        unwritten;
  logic                        list_nonempty;

  logic [DATA_BITS-1:0]        pay_rdata;
  logic [CNT_W:0]              meta_rdata;
  logic [CNT_W-1:0]            link_rd;
  logic                        del_rd;
  logic [DATA_BITS+WW-1:0]     pay_ext;

  logic                        pay_we;
  logic                        meta_we;
  logic [AW-1:0]               waddr;
  logic [CNT_W:0]              meta_wdata;

  assign accept = req_i.valid && req_i.ready;
  assign fire   = (state_q == ST_EXEC) && (!out_valid_q || rsp_o.ready);

  // slot field widened or narrowed to the memory address
  assign in_slot_ext = {{AW{1'b0}}, req_i.slot};
  assign q_slot_ext  = {{AW{1'b0}}, slot_q};
  assign slot_addr_q = q_slot_ext[AW-1:0];

  // add looks up the link of the free head, read and remove the addressed slot;
  // the address is held from the latched beat while the result waits
  always_comb begin
    if (state_q == ST_IDLE) begin
      if (rtfl_pkg::req_e'(req_i.req_type) == rtfl_pkg::REQ_ADD) begin
        raddr = free_head_q[AW-1:0];
      end else begin
        raddr = in_slot_ext[AW-1:0];
      end
    end else if (req_q == rtfl_pkg::REQ_ADD) begin
      raddr = free_head_q[AW-1:0];
    end else begin
      raddr = slot_addr_q;
    end
  end

  assign cmp_slot      = {{CNT_W{1'b0}}, slot_q};
  assign cmp_count     = {{SW{1'b0}}, used_count_q};
  assign unwritten     = (cmp_slot >= cmp_count);
  assign list_nonempty = (free_head_q < SLOTS_C);

  assign link_rd = meta_rdata[CNT_W-1:0];
  assign del_rd  = meta_rdata[CNT_W];
  assign pay_ext = {{WW{1'b0}}, pay_rdata};

  always_comb begin
    logic [AW-1:0]      target;
    logic [AW+SW-1:0]   target_ext;
    logic [CNT_W+SW-1:0] slot_as_head;

    target       = '0;
    target_ext   = '0;
    slot_as_head = {{CNT_W{1'b0}}, slot_q};

    state_d      = state_q;
    free_head_d  = free_head_q;
    used_count_d = used_count_q;
    out_valid_d  = out_valid_q;
    out_slot_d   = out_slot_q;
    out_data_d   = out_data_q;
    out_status_d = out_status_q;
    pay_we       = 1'b0;
    meta_we      = 1'b0;
    waddr        = slot_addr_q;
    meta_wdata   = {1'b0, free_head_q};

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (fire) begin
          state_d      = ST_IDLE;
          out_valid_d  = 1'b1;
          out_slot_d   = slot_q;
          out_data_d   = '0;
          out_status_d = rtfl_pkg::STAT_OK;
          case (req_q)
            rtfl_pkg::REQ_ADD: begin
              if (list_nonempty) begin
                target = free_head_q[AW-1:0];
                // a link past the empty marker is taken as the empty marker
                free_head_d = (link_rd > SLOTS_C) ? SLOTS_C : link_rd;
              end else if (used_count_q < SLOTS_C) begin
                target       = used_count_q[AW-1:0];
                used_count_d = used_count_q + CNT_W'(1);
              end else begin
                out_status_d = rtfl_pkg::STAT_FULL;
              end
              if (out_status_d == rtfl_pkg::STAT_FULL) begin
                out_slot_d = '0;
              end else begin
                target_ext = {{SW{1'b0}}, target};
                out_slot_d = target_ext[SW-1:0];
                pay_we     = 1'b1;
                meta_we    = 1'b1;
                waddr      = target;
                meta_wdata = {1'b0, free_head_q};
              end
            end
            rtfl_pkg::REQ_READ: begin
              if (unwritten) begin
                out_status_d = rtfl_pkg::STAT_UNWRITTEN;
              end else begin
                out_data_d = pay_ext[WW-1:0];
              end
            end
            rtfl_pkg::REQ_REMOVE: begin
              if (unwritten) begin
                out_status_d = rtfl_pkg::STAT_UNWRITTEN;
              end else if (del_rd) begin
                out_status_d = rtfl_pkg::STAT_DELETED;
              end else begin
                meta_we     = 1'b1;
                waddr       = slot_addr_q;
                meta_wdata  = {1'b1, free_head_q};
                free_head_d = slot_as_head[CNT_W-1:0];
              end
            end
            rtfl_pkg::REQ_NOP: begin
              out_status_d = rtfl_pkg::STAT_OK;
            end
            default: begin
              out_status_d = rtfl_pkg::STAT_OK;
            end
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      free_head_q  <= SLOTS_C;
      used_count_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      free_head_q  <= free_head_d;
      used_count_q <= used_count_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q  <= rtfl_pkg::req_e'(req_i.req_type);
      slot_q <= req_i.slot;
      data_q <= req_i.record_data[DATA_BITS-1:0];
    end
    out_slot_q   <= out_slot_d;
    out_data_q   <= out_data_d;
    out_status_q <= out_status_d;
  end

  rtfl_ram #(
    .WIDTH (DATA_BITS),
    .DEPTH (SLOTS)
  ) u_payload_ram (
    .clk_i   (clk_i),
    .we_i    (pay_we),
    .waddr_i (waddr),
    .wdata_i (data_q),
    .raddr_i (raddr),
    .rdata_o (pay_rdata)
  );

  // deleted mark on top of the free-list link
  rtfl_ram #(
    .WIDTH (CNT_W + 1),
    .DEPTH (SLOTS)
  ) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (waddr),
    .wdata_i (meta_wdata),
    .raddr_i (raddr),
    .rdata_o (meta_rdata)
  );

  assign req_i.ready     = (state_q == ST_IDLE);
  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.slot_used = out_slot_q;
  assign rsp_o.data_out  = out_data_q;
  assign rsp_o.status    = out_status_q;

`ifndef SYNTHESIS
  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_head_q <= SLOTS_C)
    else $error("free head beyond empty marker");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_count_q <= SLOTS_C)
    else $error("fill count beyond table size");

  a_count_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> used_count_q >= $past(used_count_q))
    else $error("fill count decreased");

  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_EXEC && !req_i.ready)
    else $error("accepted beat not executed");

  a_full_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == rtfl_pkg::STAT_FULL) |->
      (out_slot_q == '0 && used_count_q == SLOTS_C && free_head_q == SLOTS_C))
    else $error("table full reported while space remains");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/rtfl_ram.sv =====
// generic single-write, single-read ram with registered read data
`default_nettype none

module rtfl_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== tb/rtfl_table_monitor.sv =====
// watches both channels of the record table, predicts each result and compares it
module rtfl_table_monitor
  import rtfl_pkg::*;
#(
  parameter int unsigned SLOTS     = 256,
  parameter int unsigned DATA_BITS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rtfl_req_if         req_mon,
  rtfl_rsp_if         rsp_mon,
  output int unsigned fail_count_o,
  output int unsigned outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_used;
    logic [WORD_W-1:0] data_out;
    status_e           status;
  } table_rsp_t;

  localparam logic [WORD_W-1:0] WORD_MASK = {WORD_W{1'b1}} >> (WORD_W - DATA_BITS);

  // shadow copy of the table
  logic [8:0]        free_head;
  logic [8:0]        fill_count;
  logic [WORD_W-1:0] payload_mem [SLOTS];
  logic [8:0]        next_free   [SLOTS];
  logic              deleted     [SLOTS];

  table_rsp_t  awaited_rsps[$];
  int unsigned mismatches;

  function automatic table_rsp_t apply_request(input logic [REQ_W-1:0]  kind,
                                               input logic [SLOT_W-1:0] s,
                                               input logic [WORD_W-1:0] d);
    table_rsp_t r;
    logic [8:0] target;
    r.slot_used = s;
    r.data_out  = '0;
    r.status    = STAT_OK;
    case (kind)
      REQ_ADD: begin
        r.slot_used = '0;
        target      = '0;
        if (free_head < SLOTS) begin
          // reuse the most recently freed slot
          target    = free_head;
          free_head = next_free[target];
          if (free_head > SLOTS) free_head = 9'(SLOTS);
        end else if (fill_count < SLOTS) begin
          target     = fill_count;
          fill_count = fill_count + 9'd1;
        end else begin
          r.status = STAT_FULL;
        end
        if (r.status == STAT_OK) begin
          payload_mem[target] = d & WORD_MASK;
          deleted[target]     = 1'b0;
          r.slot_used         = target[SLOT_W-1:0];
        end
      end
      REQ_NOP: begin
      end
      default: begin
        if (s >= fill_count || s >= SLOTS) begin
          r.status = STAT_UNWRITTEN;
        end else if (kind == REQ_READ) begin
          // deleted slots still return their old payload
          r.data_out = payload_mem[s];
        end else if (deleted[s]) begin
          r.status = STAT_DELETED;
        end else begin
          deleted[s]   = 1'b1;
          next_free[s] = free_head;
          free_head    = {1'b0, s};
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    table_rsp_t want;
    if (!rst_ni) begin
      free_head  = 9'(SLOTS);
      fill_count = '0;
      awaited_rsps.delete();
    end else begin
      // a result never leaves in the cycle of its own request, so pop first
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (awaited_rsps.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result beat: expected none, %s %0d data %h status %0d",
                   $time, "actual slot", rsp_mon.slot_used, rsp_mon.data_out,
                   rsp_mon.status);
        end else begin
          want = awaited_rsps.pop_front();
          if (rsp_mon.slot_used !== want.slot_used) begin
            mismatches++;
            $display("%0t: slot_used mismatch: expected %0d actual %0d",
                     $time, want.slot_used, rsp_mon.slot_used);
          end
          if (rsp_mon.data_out !== want.data_out) begin
            mismatches++;
            $display("%0t: data_out mismatch: expected %h actual %h",
                     $time, want.data_out, rsp_mon.data_out);
          end
          if (rsp_mon.status !== want.status) begin
            mismatches++;
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, want.status, rsp_mon.status);
          end
        end
      end
      if (req_mon.valid && req_mon.ready)
        awaited_rsps.push_back(apply_request(req_mon.req_type, req_mon.slot,
                                             req_mon.record_data));
    end
    fail_count_o  <= mismatches;
    outstanding_o <= awaited_rsps.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// stimulus, clock, reset and verdict for the record table free list unit
module tb_top;
  import rtfl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned outstanding;
  int          sent_count;
  int          fill_guess;

  rtfl_req_if req_ch ();
  rtfl_rsp_if rsp_ch ();

  record_table_free_list_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  rtfl_table_monitor table_mon (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_mon       (req_ch),
    .rsp_mon       (rsp_ch),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    rst_ni <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  // one request beat, after a random gap outside burst stretches
  task automatic send_req(input req_e kind, input logic [SLOT_W-1:0] s,
                          input logic [WORD_W-1:0] d);
    int gap;
    gap = (sent_count % 200 < 60) ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= kind;
    req_ch.slot        <= s;
    req_ch.record_data <= d;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    sent_count++;
    if (kind == REQ_ADD && fill_guess < 256) fill_guess++;
  endtask

  // result side: random stalls, burst stretches, and one long hold-off
  initial begin
    int beats;
    int gap;
    beats = 0;
    rsp_ch.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (beats == 400) gap = 120;
      else gap = (beats % 170 < 50) ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!rsp_ch.valid) @(posedge clk_i);
      beats++;
    end
  end

  initial begin
    int                roll;
    int                add_pct;
    int                read_pct;
    int                rem_pct;
    req_e              kind;
    logic [SLOT_W-1:0] s;
    logic [WORD_W-1:0] d;
    sent_count = 0;
    fill_guess = 0;
    req_ch.valid       <= 1'b0;
    req_ch.req_type    <= REQ_NOP;
    req_ch.slot        <= '0;
    req_ch.record_data <= '0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);

    // directed: empty table, extremes, double remove, reuse order
    send_req(REQ_READ,   8'd0,   '0);
    send_req(REQ_REMOVE, 8'd255, '1);
    send_req(REQ_NOP,    8'hAA,  '1);
    send_req(REQ_ADD,    8'd255, '0);
    send_req(REQ_ADD,    8'd0,   '1);
    send_req(REQ_ADD,    8'd0,   64'h5555_5555_5555_5555);
    send_req(REQ_READ,   8'd0,   '0);
    send_req(REQ_READ,   8'd1,   '0);
    send_req(REQ_READ,   8'd2,   '0);
    send_req(REQ_READ,   8'd3,   '0);
    send_req(REQ_REMOVE, 8'd1,   '0);
    send_req(REQ_REMOVE, 8'd1,   '0);
    send_req(REQ_READ,   8'd1,   '0);
    send_req(REQ_REMOVE, 8'd0,   '0);
    send_req(REQ_ADD,    8'd7,   64'hA5A5_A5A5_5A5A_5A5A);
    send_req(REQ_ADD,    8'd0,   64'h8000_0000_0000_0001);
    send_req(REQ_ADD,    8'd0,   64'h0123_4567_89AB_CDEF);
    send_req(REQ_READ,   8'd0,   '0);
    send_req(REQ_READ,   8'd1,   '0);
    send_req(REQ_READ,   8'd3,   '0);
    send_req(REQ_READ,   8'd4,   '0);
    send_req(REQ_NOP,    8'd255, '1);

    // random: fill past full, then drain, then mixed traffic
    for (int i = 0; i < 1230; i++) begin
      if (i < 550) begin
        add_pct = 70; read_pct = 12; rem_pct = 13;
      end else if (i < 900) begin
        add_pct = 20; read_pct = 25; rem_pct = 50;
      end else begin
        add_pct = 45; read_pct = 20; rem_pct = 30;
      end
      roll = $urandom_range(0, 99);
      if (roll < add_pct) kind = REQ_ADD;
      else if (roll < add_pct + read_pct) kind = REQ_READ;
      else if (roll < add_pct + read_pct + rem_pct) kind = REQ_REMOVE;
      else kind = REQ_NOP;
      if (fill_guess == 0 || $urandom_range(0, 3) == 0) s = SLOT_W'($urandom_range(0, 255));
      else s = SLOT_W'($urandom_range(0, fill_guess - 1));
      case ($urandom_range(0, 9))
        0: d = '0;
        1: d = '1;
        default: d = {$urandom, $urandom};
      endcase
      send_req(kind, s, d);
    end
    req_ch.valid <= 1'b0;

    // let the count of pending results take in the last beat
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/rtfl_pkg.sv
rtl/core/rtfl_if.sv
rtl/core/rtfl_ram.sv
rtl/core/record_table_free_list_unit.sv
tb/rtfl_table_monitor.sv
tb/tb_top.sv
